// ----- rtl/ipfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfd_pkg: shared types and constants of the IPv4 forwarding decision block
// Request and result payloads, route entry layout, register map, action
// codes and sequencer states.
// ----------------------------------------------------------------------------
package ipfd_pkg;

	// Default sizes
	localparam int ROUTE_ENTRIES_DEF = 16;
	localparam int PORT_COUNT_DEF    = 4;

	// Router port address registers in the register map
	localparam int ADDR_REGS = 4;

	// APB address width: five registers at 4-byte spacing
	localparam int PADDR_W = 5;

	// Register indexes (paddr[4:2])
	localparam logic [2:0] REG_PORT0        = 3'd0;
	localparam logic [2:0] REG_PORT1        = 3'd1;
	localparam logic [2:0] REG_PORT2        = 3'd2;
	localparam logic [2:0] REG_PORT3        = 3'd3;
	localparam logic [2:0] REG_PORTS_IN_USE = 3'd4;

	// Request kinds
	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// Packet header codes
	localparam logic [7:0] PROTO_ICMP        = 8'd1;
	localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;

	typedef enum logic [2:0] {
		ACT_FORWARD      = 3'd0,
		ACT_ECHO_REPLY   = 3'd1,
		ACT_PORT_UNREACH = 3'd2,
		ACT_NET_UNREACH  = 3'd3,
		ACT_WRITE_DONE   = 3'd4
	} act_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PORT,
		ST_WALK,
		ST_FIN
	} st_t;

	typedef struct packed {
		logic        req_type;
		logic [3:0]  entry_index;
		logic        entry_valid;
		logic [31:0] entry_prefix;
		logic [31:0] entry_mask;
		logic [31:0] entry_gateway;
		logic [1:0]  entry_port;
		logic [31:0] dest_address;
		logic [7:0]  ip_protocol;
		logic [7:0]  icmp_kind;
		logic [1:0]  arrival_port;
	} req_t;

	typedef struct packed {
		act_t        action;
		logic [31:0] hop_addr;
		logic [1:0]  egress_port;
	} rsp_t;

	typedef struct packed {
		logic [31:0] prefix;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [1:0]  port;
	} route_t;

	typedef struct packed {
		logic [ADDR_REGS-1:0][31:0] port_addr;
		logic [2:0]                 ports_in_use;
	} cfg_t;

	// Best match so far, fed back into the compare unit
	typedef struct packed {
		logic        found;
		logic [31:0] mask;
	} best_t;

endpackage

// ----- rtl/ipfd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfd_if: request and result channels
// Valid/ready channels carrying the request and result payloads.
// ----------------------------------------------------------------------------
interface ipfd_req_if;
	logic            valid;
	logic            ready;
	ipfd_pkg::req_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface ipfd_rsp_if;
	logic            valid;
	logic            ready;
	ipfd_pkg::rsp_t  data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/ipv4_forwarding_decision.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_forwarding_decision: IPv4 forwarding decision block
// Route table with longest-prefix-match lookup and local port check.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: a route write (req_type 0) or a packet lookup
//   (req_type 1). rsp returns exactly one result per request. Router port
//   addresses and ports_in_use are set over the APB port; the user is to
//   write them only while idle, the block itself does not enforce this.
//   An accepted write goes through the finish state to the output
//   register, and only after that is the next request taken. A lookup first
//   runs the port address check; a local hit finishes there the same way.
//   Otherwise the shared route compare unit walks the table, one entry per
//   cycle through the registered-read table RAM; no new request is taken
//   until its result has left the finish state. After reset a clearing pass
//   over all ROUTE_ENTRIES entries resets the active bits; req.ready stays
//   low meanwhile, APB writes are taken as usual. Results sit in an output
//   register: a new request is accepted while a result waits, and the
//   sequencer holds its next result until rsp.ready frees that register.
// ----------------------------------------------------------------------------
module ipv4_forwarding_decision #(
	parameter int ROUTE_ENTRIES = ipfd_pkg::ROUTE_ENTRIES_DEF,
	parameter int PORT_COUNT    = ipfd_pkg::PORT_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ipfd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	ipfd_req_if.sink                     req,
	ipfd_rsp_if.source                   rsp
);

	localparam int IDX_W = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(ROUTE_ENTRIES - 1);
	localparam int RT_W = $bits(ipfd_pkg::route_t);

	ipfd_pkg::cfg_t   cfg;
	ipfd_pkg::st_t    state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;

	logic [31:0]      dest_q;
	logic [7:0]       proto_q;
	logic [7:0]       kind_q;
	logic [1:0]       arrival_q;

	ipfd_pkg::best_t  best_q, best_d;
	logic [31:0]      best_gw_q, best_gw_d;
	logic [1:0]       best_port_q, best_port_d;

	ipfd_pkg::rsp_t   res_q, res_d;
	logic             rsp_valid_q;
	ipfd_pkg::rsp_t   rsp_data_q;
	logic             out_ld;

	logic             accept;
	logic             wr_acc;
	logic             in_range;

	logic             act_we;
	logic [IDX_W-1:0] act_waddr;
	logic             act_wdata;
	logic [IDX_W-1:0] raddr;
	logic             act_rdata;
	logic [RT_W-1:0]  rt_rdata;
	ipfd_pkg::route_t rd_route;
	ipfd_pkg::route_t rt_wentry;
	logic             take;

	logic             port_hit;
	logic [1:0]       hit_port;

	// --------------------------------------------------------------------
	// Configuration registers
	ipfd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// --------------------------------------------------------------------
	// Request handshake and table write port
	assign req.ready = (state_q == ipfd_pkg::ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign wr_acc    = accept && (req.data.req_type == ipfd_pkg::REQ_WRITE);
	assign in_range  = (32'(req.data.entry_index) < 32'(ROUTE_ENTRIES));

	assign act_we    = (state_q == ipfd_pkg::ST_CLEAR) || (wr_acc && in_range);
	assign act_waddr = (state_q == ipfd_pkg::ST_CLEAR) ? idx_q
	                                                    : IDX_W'(req.data.entry_index);
	assign act_wdata = (state_q == ipfd_pkg::ST_CLEAR) ? 1'b0 : req.data.entry_valid;

	assign rt_wentry.prefix  = req.data.entry_prefix;
	assign rt_wentry.mask    = req.data.entry_mask;
	assign rt_wentry.gateway = req.data.entry_gateway;
	assign rt_wentry.port    = req.data.entry_port;

	// walk read address: entry 0 during the port check, then one ahead
	assign raddr = (state_q == ipfd_pkg::ST_WALK && idx_q != LAST) ? idx_q + 1'b1
	               : (state_q == ipfd_pkg::ST_WALK) ? idx_q : '0;

	ipfd_ram #(
		.WIDTH (1),
		.DEPTH (ROUTE_ENTRIES)
	) u_active_ram (
		.clk   (clk),
		.we    (act_we),
		.waddr (act_waddr),
		.wdata (act_wdata),
		.raddr (raddr),
		.rdata (act_rdata)
	);

	ipfd_ram #(
		.WIDTH (RT_W),
		.DEPTH (ROUTE_ENTRIES)
	) u_route_ram (
		.clk   (clk),
		.we    (wr_acc && in_range),
		.waddr (IDX_W'(req.data.entry_index)),
		.wdata (rt_wentry),
		.raddr (raddr),
		.rdata (rt_rdata)
	);

	assign rd_route = ipfd_pkg::route_t'(rt_rdata);

	// --------------------------------------------------------------------
	// Shared route compare unit
	ipfd_route_cmp u_cmp (
		.dest   (dest_q),
		.active (act_rdata),
		.route  (rd_route),
		.best   (best_q),
		.take   (take)
	);

	// --------------------------------------------------------------------
	// Local port address check, lowest port wins
	always_comb begin
		port_hit = 1'b0;
		hit_port = '0;
		for (int i = 0; i < ipfd_pkg::ADDR_REGS; i++) begin
			if (!port_hit && (i < PORT_COUNT) &&
			    (32'(i) < 32'(cfg.ports_in_use)) &&
			    (cfg.port_addr[i] == dest_q)) begin
				port_hit = 1'b1;
				hit_port = 2'(i);
			end
		end
	end

	// --------------------------------------------------------------------
	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipfd_pkg::ST_CLEAR;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// Sequencer next state and result
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		best_d      = best_q;
		best_gw_d   = best_gw_q;
		best_port_d = best_port_q;
		res_d       = res_q;
		out_ld      = 1'b0;
		case (state_q)
			ipfd_pkg::ST_CLEAR: begin
				if (idx_q == LAST) begin
					idx_d   = '0;
					state_d = ipfd_pkg::ST_IDLE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ipfd_pkg::ST_IDLE: begin
				if (accept) begin
					if (req.data.req_type == ipfd_pkg::REQ_WRITE) begin
						res_d.action      = ipfd_pkg::ACT_WRITE_DONE;
						res_d.hop_addr    = '0;
						res_d.egress_port = '0;
						state_d           = ipfd_pkg::ST_FIN;
					end else begin
						idx_d        = '0;
						best_d.found = 1'b0;
						state_d      = ipfd_pkg::ST_PORT;
					end
				end
			end
			ipfd_pkg::ST_PORT: begin
				if (port_hit) begin
					res_d.hop_addr = '0;
					if (proto_q == ipfd_pkg::PROTO_ICMP &&
					    kind_q == ipfd_pkg::ICMP_ECHO_REQUEST) begin
						res_d.action      = ipfd_pkg::ACT_ECHO_REPLY;
						res_d.egress_port = arrival_q;
					end else begin
						res_d.action      = ipfd_pkg::ACT_PORT_UNREACH;
						res_d.egress_port = hit_port;
					end
					state_d = ipfd_pkg::ST_FIN;
				end else begin
					state_d = ipfd_pkg::ST_WALK;
				end
			end
			ipfd_pkg::ST_WALK: begin
				if (take) begin
					best_d.found = 1'b1;
					best_d.mask  = rd_route.mask;
					best_gw_d    = rd_route.gateway;
					best_port_d  = rd_route.port;
				end
				if (idx_q == LAST) begin
					if (best_d.found) begin
						res_d.action      = ipfd_pkg::ACT_FORWARD;
						res_d.hop_addr    = (best_gw_d == 32'd0) ? dest_q : best_gw_d;
						res_d.egress_port = best_port_d;
					end else begin
						res_d.action      = ipfd_pkg::ACT_NET_UNREACH;
						res_d.hop_addr    = '0;
						res_d.egress_port = arrival_q;
					end
					idx_d   = '0;
					state_d = ipfd_pkg::ST_FIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ipfd_pkg::ST_FIN: begin
				if (!rsp_valid_q || rsp.ready) begin
					out_ld  = 1'b1;
					state_d = ipfd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ipfd_pkg::ST_IDLE;
			end
		endcase
	end

	// --------------------------------------------------------------------
	// Lookup operands, best match and pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			dest_q    <= req.data.dest_address;
			proto_q   <= req.data.ip_protocol;
			kind_q    <= req.data.icmp_kind;
			arrival_q <= req.data.arrival_port;
		end
		best_gw_q   <= best_gw_d;
		best_port_q <= best_port_d;
		res_q       <= res_d;
		if (out_ld) begin
			rsp_data_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else begin
			best_q <= best_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_ld) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	// --------------------------------------------------------------------
	// Assertions
	a_write_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.action == ipfd_pkg::ACT_WRITE_DONE |->
			rsp.data.hop_addr == 32'd0 && rsp.data.egress_port == 2'd0)
		else $error("write done result carries nonzero hop or port");

	a_nonfwd_hop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.action != ipfd_pkg::ACT_FORWARD |->
			rsp.data.hop_addr == 32'd0)
		else $error("next hop nonzero on a non-forward result");

	a_lookup_to_port: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.data.req_type == ipfd_pkg::REQ_LOOKUP |=>
			state_q == ipfd_pkg::ST_PORT)
		else $error("accepted lookup did not start the port check");

	a_fin_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ipfd_pkg::ST_FIN && (!rsp_valid_q || rsp.ready) |=>
			rsp_valid_q && state_q == ipfd_pkg::ST_IDLE)
		else $error("finished result not moved into the output register");

endmodule

// ----- rtl/ipfd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfd_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ipfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/ipfd_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfd_cfg: APB register file
// Router port addresses and the number of ports in use.
// ----------------------------------------------------------------------------
module ipfd_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ipfd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output ipfd_pkg::cfg_t               cfg
);

	ipfd_pkg::cfg_t cfg_q;
	logic           wr_en;
	logic [2:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				ipfd_pkg::REG_PORT0:        cfg_q.port_addr[0] <= pwdata;
				ipfd_pkg::REG_PORT1:        cfg_q.port_addr[1] <= pwdata;
				ipfd_pkg::REG_PORT2:        cfg_q.port_addr[2] <= pwdata;
				ipfd_pkg::REG_PORT3:        cfg_q.port_addr[3] <= pwdata;
				ipfd_pkg::REG_PORTS_IN_USE: cfg_q.ports_in_use <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			ipfd_pkg::REG_PORT0:        prdata = cfg_q.port_addr[0];
			ipfd_pkg::REG_PORT1:        prdata = cfg_q.port_addr[1];
			ipfd_pkg::REG_PORT2:        prdata = cfg_q.port_addr[2];
			ipfd_pkg::REG_PORT3:        prdata = cfg_q.port_addr[3];
			ipfd_pkg::REG_PORTS_IN_USE: prdata = {29'd0, cfg_q.ports_in_use};
			default:                    prdata = '0;
		endcase
	end

endmodule

// ----- rtl/ipfd_route_cmp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipfd_route_cmp: route compare unit
// Masked prefix compare of one entry against the destination, plus the
// longer-mask test against the best match so far.
// ----------------------------------------------------------------------------
module ipfd_route_cmp (
	input  logic [31:0]            dest,
	input  logic                   active,
	input  ipfd_pkg::route_t       route,
	input  ipfd_pkg::best_t        best,
	output logic                   take
);

	logic match;

	// prefix match under the entry mask
	assign match = active && (((dest ^ route.prefix) & route.mask) == 32'd0);

	// strictly longer mask replaces; equal masks keep the earlier entry
	assign take = match && (!best.found || (route.mask > best.mask));

endmodule

// ----- dv/ipv4_forwarding_decision_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_forwarding_decision_tb: self-checking bench for the forwarding block
// Route writes and packet lookups are sent with random gaps on both channels.
// A scoreboard keeps its own route table and port addresses, works out the
// decision for every accepted request and checks the results in order. The
// port registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module ipv4_forwarding_decision_tb;
	import ipfd_pkg::*;

	localparam int ENTRIES     = ROUTE_ENTRIES_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 142;
	localparam int HOLD_AFTER  = 400;
	localparam int HOLD_CYCLES = 300;

	// Scoreboard: predicts each decision and checks results in order
	class route_scoreboard;
		logic [31:0] port_addr [ADDR_REGS];
		logic [2:0]  ports_in_use;
		bit          route_on [ENTRIES];
		route_t      routes [ENTRIES];
		rsp_t        pending_decisions [$];
		int          mismatches;
		int          results_seen;

		function new();
			foreach (port_addr[i]) port_addr[i] = '0;
			foreach (routes[i]) begin
				route_on[i] = 1'b0;
				routes[i]   = '0;
			end
			ports_in_use = '0;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void set_register(input logic [2:0] idx, input logic [31:0] value);
			case (idx)
				REG_PORT0:        port_addr[0] = value;
				REG_PORT1:        port_addr[1] = value;
				REG_PORT2:        port_addr[2] = value;
				REG_PORT3:        port_addr[3] = value;
				REG_PORTS_IN_USE: ports_in_use = value[2:0];
				default: ;
			endcase
		endfunction

		function rsp_t decide(input req_t r);
			rsp_t res;
			int   limit;
			int   best;
			int   i;
			bit   found;
			res.action      = ACT_WRITE_DONE;
			res.hop_addr    = '0;
			res.egress_port = '0;
			if (r.req_type == REQ_WRITE) begin
				route_on[r.entry_index] = r.entry_valid;
				routes[r.entry_index]   = '{r.entry_prefix, r.entry_mask,
					r.entry_gateway, r.entry_port};
				return res;
			end
			// local delivery, lowest port first; count saturates
			limit = ports_in_use;
			if (limit > PORT_COUNT_DEF) limit = PORT_COUNT_DEF;
			if (limit > ADDR_REGS) limit = ADDR_REGS;
			for (i = 0; i < limit; i++) begin
				if (port_addr[i] == r.dest_address) begin
					if (r.ip_protocol == PROTO_ICMP && r.icmp_kind == ICMP_ECHO_REQUEST) begin
						res.action      = ACT_ECHO_REPLY;
						res.egress_port = r.arrival_port;
					end else begin
						res.action      = ACT_PORT_UNREACH;
						res.egress_port = i[1:0];
					end
					return res;
				end
			end
			// longest prefix match; strict compare keeps the first on a tie
			found = 1'b0;
			best  = 0;
			for (i = 0; i < ENTRIES; i++) begin
				if (route_on[i] &&
				    (r.dest_address & routes[i].mask) == (routes[i].prefix & routes[i].mask) &&
				    (!found || routes[i].mask > routes[best].mask)) begin
					best  = i;
					found = 1'b1;
				end
			end
			if (!found) begin
				res.action      = ACT_NET_UNREACH;
				res.egress_port = r.arrival_port;
				return res;
			end
			res.action      = ACT_FORWARD;
			res.hop_addr    = (routes[best].gateway == '0) ? r.dest_address : routes[best].gateway;
			res.egress_port = routes[best].port;
			return res;
		endfunction

		function void note_request(input req_t r);
			pending_decisions.push_back(decide(r));
		endfunction

		function void check_result(input rsp_t got);
			rsp_t want;
			results_seen++;
			if (pending_decisions.size() == 0) begin
				$error("unexpected result: action %0d hop_addr %h egress_port %0d",
					got.action, got.hop_addr, got.egress_port);
				mismatches++;
				return;
			end
			want = pending_decisions.pop_front();
			if (got.action !== want.action) begin
				$error("action: expected %0d, got %0d", want.action, got.action);
				mismatches++;
			end
			if (got.hop_addr !== want.hop_addr) begin
				$error("hop_addr: expected %h, got %h", want.hop_addr, got.hop_addr);
				mismatches++;
			end
			if (got.egress_port !== want.egress_port) begin
				$error("egress_port: expected %0d, got %0d", want.egress_port, got.egress_port);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	ipfd_req_if req_ch();
	ipfd_rsp_if rsp_ch();

	route_scoreboard sb = new();
	int              requests_sent;
	int              cycles;
	bit              held_off;

	ipv4_forwarding_decision dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Result side: random stalls, calm stretches and one long hold-off
	initial begin : result_sink
		int gap;
		rsp_ch.ready = 1'b0;
		held_off     = 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (!held_off && sb.results_seen >= HOLD_AFTER) begin
				gap      = HOLD_CYCLES;
				held_off = 1'b1;
			end else if (((sb.results_seen / 55) % 5) == 2) begin
				gap = 0;
			end else begin
				gap = $urandom_range(0, 5);
			end
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			sb.check_result(rsp_ch.data);
		end
	end

	// APB write: setup then access; psel stays up across back-to-back writes
	task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		sb.set_register(idx, value);
	endtask

	task automatic configure(input logic [31:0] a0, input logic [31:0] a1,
		input logic [31:0] a2, input logic [31:0] a3, input logic [2:0] used);
		write_register(REG_PORT0, a0);
		write_register(REG_PORT1, a1);
		write_register(REG_PORT2, a2);
		write_register(REG_PORT3, a3);
		write_register(REG_PORTS_IN_USE, {29'd0, used});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Random port addresses, sometimes shared; the saturating count gets extremes
	task automatic configure_phase(input int used);
		logic [31:0] addr [ADDR_REGS];
		for (int i = 0; i < ADDR_REGS; i++) begin
			addr[i] = $urandom;
			if (i > 0 && $urandom_range(0, 3) == 0) addr[i] = addr[$urandom_range(0, i - 1)];
		end
		if (used == 7) begin
			addr[0] = 32'hFFFF_FFFF;
			addr[1] = 32'h0000_0000;
			addr[3] = 32'hFFFF_FFFF;
		end
		configure(addr[0], addr[1], addr[2], addr[3], used[2:0]);
	endtask

	// Offer one request after a random gap and wait until it is taken
	task automatic send_request(input req_t r);
		int gap;
		if (((requests_sent / 40) % 5) == 4) gap = 0;
		else gap = $urandom_range(0, 5);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(r);
		requests_sent++;
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.pending_decisions.size() != 0) @(posedge clk);
	endtask

	// Mostly routes and lookups aimed at known prefixes or port addresses
	function automatic req_t random_request();
		req_t        r;
		int          len;
		int          j;
		int          pick;
		logic [31:0] net_mask;
		r.req_type    = ($urandom_range(0, 9) < 3) ? REQ_WRITE : REQ_LOOKUP;
		r.entry_index = 4'($urandom);
		r.entry_valid = ($urandom_range(0, 7) != 0);
		len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4) * 8 : $urandom_range(0, 32);
		r.entry_mask  = ($urandom_range(0, 7) == 0) ? $urandom : (32'hFFFF_FFFF << (32 - len));
		j = $urandom_range(0, ENTRIES - 1);
		net_mask = sb.routes[j].mask;
		if ($urandom_range(0, 1) == 0)
			r.entry_prefix = (sb.routes[j].prefix & net_mask) | ($urandom & ~net_mask);
		else
			r.entry_prefix = $urandom;
		r.entry_gateway = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
		r.entry_port    = 2'($urandom);
		j = $urandom_range(0, ENTRIES - 1);
		net_mask = sb.routes[j].mask;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			r.dest_address = (sb.routes[j].prefix & net_mask) | ($urandom & ~net_mask);
		else if (pick < 8)
			r.dest_address = sb.port_addr[$urandom_range(0, ADDR_REGS - 1)];
		else
			r.dest_address = $urandom;
		case ($urandom_range(0, 3))
			0: begin
				r.ip_protocol = PROTO_ICMP;
				r.icmp_kind   = ICMP_ECHO_REQUEST;
			end
			1: begin
				r.ip_protocol = PROTO_ICMP;
				r.icmp_kind   = 8'($urandom);
			end
			default: begin
				r.ip_protocol = 8'($urandom);
				r.icmp_kind   = ($urandom_range(0, 1) == 0) ? ICMP_ECHO_REQUEST : 8'($urandom);
			end
		endcase
		r.arrival_port = 2'($urandom);
		return r;
	endfunction

	task automatic route_write(input logic [3:0] idx, input logic on, input logic [31:0] prefix,
		input logic [31:0] mask, input logic [31:0] gateway, input logic [1:0] port);
		req_t r;
		r = random_request();
		r.req_type      = REQ_WRITE;
		r.entry_index   = idx;
		r.entry_valid   = on;
		r.entry_prefix  = prefix;
		r.entry_mask    = mask;
		r.entry_gateway = gateway;
		r.entry_port    = port;
		send_request(r);
	endtask

	task automatic packet_lookup(input logic [31:0] dest, input logic [7:0] proto,
		input logic [7:0] kind, input logic [1:0] arrival);
		req_t r;
		r = random_request();
		r.req_type     = REQ_LOOKUP;
		r.dest_address = dest;
		r.ip_protocol  = proto;
		r.icmp_kind    = kind;
		r.arrival_port = arrival;
		send_request(r);
	endtask

	// Main sequence
	initial begin : stimulus
		int port_usage [8];
		port_usage    = '{0, 4, 7, 2, 1, 3, 5, 6};
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		req_ch.valid  = 1'b0;
		req_ch.data   = '0;
		requests_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// ports 0 and 2 share an address, port 3 sits at 0.0.0.0
		configure(32'hC0A8_0001, 32'hC0A8_0101, 32'hC0A8_0001, 32'h0000_0000, 3'd4);

		// local handling on an empty table
		packet_lookup(32'h0808_0808, 8'd17, 8'd0, 2'd1);
		packet_lookup(32'hC0A8_0001, PROTO_ICMP, ICMP_ECHO_REQUEST, 2'd3);
		packet_lookup(32'hC0A8_0001, PROTO_ICMP, 8'd0, 2'd1);
		packet_lookup(32'hC0A8_0101, 8'd6, ICMP_ECHO_REQUEST, 2'd0);
		packet_lookup(32'h0000_0000, PROTO_ICMP, ICMP_ECHO_REQUEST, 2'd2);

		// table: /8, two equal /16s, default route, host route
		route_write(4'd0, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 32'h0000_0000, 2'd1);
		route_write(4'd1, 1'b1, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0001, 2'd2);
		route_write(4'd2, 1'b1, 32'h0A01_FFFF, 32'hFFFF_0000, 32'h0000_0001, 2'd3);
		route_write(4'd15, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 2'd0);
		route_write(4'd3, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 2'd3);
		packet_lookup(32'h0A02_0304, 8'd6, 8'd0, 2'd0);
		packet_lookup(32'h0A01_0909, 8'd17, 8'd0, 2'd0);
		packet_lookup(32'h0B00_0001, PROTO_ICMP, ICMP_ECHO_REQUEST, 2'd1);
		packet_lookup(32'hFFFF_FFFF, 8'hFF, 8'hFF, 2'd3);

		// clear a slot, then a later longer mask wins
		route_write(4'd1, 1'b0, 32'h0A01_0000, 32'hFFFF_0000, 32'hC0A8_0001, 2'd2);
		packet_lookup(32'h0A01_0909, 8'd17, 8'd0, 2'd0);
		route_write(4'd14, 1'b1, 32'h0A01_0900, 32'hFFFF_FF00, 32'h0000_0000, 2'd2);
		packet_lookup(32'h0A01_0909, 8'd17, 8'd0, 2'd0);
		route_write(4'd15, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 2'd0);
		packet_lookup(32'h0B00_0001, 8'd6, 8'd0, 2'd2);
		route_write(4'd4, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 2'd3);
		packet_lookup(32'h8000_0000, 8'hFF, 8'hFF, 2'd3);

		// random phases, one port setting each
		for (int phase = 0; phase < 8; phase++) begin
			drain();
			configure_phase(port_usage[phase]);
			repeat (PHASE_ITEMS) send_request(random_request());
		end

		drain();
		repeat (25) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending_decisions.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/ipfd_pkg.sv
rtl/ipfd_if.sv
rtl/ipfd_ram.sv
rtl/ipfd_cfg.sv
rtl/ipfd_route_cmp.sv
rtl/ipv4_forwarding_decision.sv
dv/ipv4_forwarding_decision_tb.sv
